// ===== rtl/core/mdc_pkg.sv =====
package mdc_pkg;

  // block size and store
  localparam int unsigned BLOCK_FRAMES_DEF = 64;

  // sample formats
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned PCM_W    = 16;
  localparam int unsigned GAIN_W   = 12;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned GAIN_SHIFT = 8;

  localparam logic signed [PCM_W-1:0] PCM_MAX = 16'sh7FFF;
  localparam logic signed [PCM_W-1:0] PCM_MIN = 16'sh8000;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SLOT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BUDGET = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 12'd256;

  // one stereo frame
  typedef struct packed {
    logic signed [WORD_W-1:0] slot0_word;
    logic signed [WORD_W-1:0] slot1_word;
    logic                     last_frame;
  } mdc_in_t;

  // one pcm result with block statistics
  typedef struct packed {
    logic signed [PCM_W-1:0]    pcm_sample;
    logic                       sample_valid;
    logic                       last_of_block;
    logic signed [SAMPLE_W-1:0] active_mean;
    logic [SAMPLE_W-1:0]        slot0_peak;
    logic [SAMPLE_W-1:0]        slot1_peak;
    logic [CNT_W-1:0]           frames_captured;
  } mdc_out_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_LD,
    S_DIV,
    S_PK_RD,
    S_PK_CMP,
    S_BUDGET,
    S_EM_RD,
    S_EM_MUL,
    S_EM_OUT,
    S_WAIT
  } mdc_state_e;

endpackage

// ===== rtl/core/mdc_in_if.sv =====
interface mdc_in_if import mdc_pkg::*; ();
  logic    valid;
  logic    ready;
  mdc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/mdc_out_if.sv =====
interface mdc_out_if import mdc_pkg::*; ();
  logic     valid;
  logic     ready;
  mdc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/mic_block_dc_removal_pcm_core.sv =====
// Stereo microphone block DC removal. Each frame transfer stores both slots (raw word
// shifted right by 8 to 24 bits) and accumulates per-slot sums; a frame that does not
// close a block keeps the core in capture. A block closes on last_frame or on its BLOCK_FRAMES-th
// frame. The block then computes both slot means with one shared restoring divider, one
// quotient bit per cycle (SUM_W = 24 + ceil(log2(BLOCK_FRAMES))), walks the frame store
// for the peak deviations (a read, then a compare, per frame; single read port), and
// emits (sample - mean) * gain >>> 8 saturated to 16 bits for the active slot, one
// result at a time (read, multiply, saturate, then held until the output accepts it),
// up to the remaining frame budget. With no budget left a single statistics-only
// result (sample_valid = 0) is emitted. No frame is taken from a block's closing
// frame until its last result is accepted. Configuration writes are meant for idle
// periods only; writing frame_budget also clears the captured frame count.
module mic_block_dc_removal_pcm_core
  import mdc_pkg::*;
#(
  parameter int unsigned BLOCK_FRAMES = BLOCK_FRAMES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  mdc_in_if.sink                in_ch,
  mdc_out_if.source             out_ch
);

  localparam int unsigned AW    = (BLOCK_FRAMES > 1) ? $clog2(BLOCK_FRAMES) : 1;
  localparam int unsigned CW    = $clog2(BLOCK_FRAMES + 1);
  localparam int unsigned SUM_W = SAMPLE_W + AW;
  localparam int unsigned DCW   = $clog2(SUM_W);
  localparam int unsigned DIF_W = SAMPLE_W + 1;
  localparam int unsigned PRD_W = DIF_W + GAIN_W + 1;
  localparam int unsigned SH_W  = PRD_W - GAIN_SHIFT;

  mdc_state_e state_q, state_d;

  // control registers
  logic [CW-1:0]           fib_q;
  logic signed [SUM_W-1:0] sum0_q, sum1_q;
  logic [CNT_W-1:0]        captured_q;
  logic [GAIN_W-1:0]       gain_q;
  logic                    slot_q;
  logic [CNT_W-1:0]        budget_q;
  logic                    out_valid_q;

  // datapath registers
  logic [CW-1:0]              n_q;
  logic [CW-1:0]              walk_q;
  logic [CW-1:0]              emit_q;
  logic [SUM_W-1:0]           quo_q;
  logic [CW-1:0]              rem_q;
  logic [DCW-1:0]             dcnt_q;
  logic                       dslot_q;
  logic signed [SAMPLE_W-1:0] mean0_q, mean1_q;
  logic [SAMPLE_W-1:0]        peak0_q, peak1_q;
  logic [2*SAMPLE_W-1:0]      rd_q;
  logic signed [PRD_W-1:0]    prod_q;
  mdc_out_t                   out_q;

  logic [2*SAMPLE_W-1:0] mem [BLOCK_FRAMES];

  logic in_acc, out_acc, closing;
  logic signed [SAMPLE_W-1:0] s0, s1;

  assign in_ch.ready = (state_q == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_valid_q && out_ch.ready;
  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = out_q;

  assign s0 = in_ch.data.slot0_word[WORD_W-1:GAIN_SHIFT];
  assign s1 = in_ch.data.slot1_word[WORD_W-1:GAIN_SHIFT];
  assign closing = in_ch.data.last_frame || (fib_q == CW'(BLOCK_FRAMES - 1));

  // shared divider step: one quotient bit per cycle
  logic signed [SUM_W-1:0] div_sum;
  logic [SUM_W-1:0]        div_mag;
  logic [CW:0]             rem_sh;
  logic                    rem_ge;
  logic [CW-1:0]           rem_d;
  logic [SUM_W-1:0]        quo_d;
  logic [SUM_W-1:0]        quo_signed;

  assign div_sum = dslot_q ? sum1_q : sum0_q;
  assign div_mag = div_sum[SUM_W-1] ? SUM_W'(-div_sum) : SUM_W'(div_sum);
  assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, n_q};
  assign rem_d   = rem_ge ? CW'(rem_sh - {1'b0, n_q}) : rem_sh[CW-1:0];
  assign quo_d   = {quo_q[SUM_W-2:0], rem_ge};
  assign quo_signed = div_sum[SUM_W-1] ? SUM_W'(-quo_d) : quo_d;

  // absolute deviation of both slots for the peak walk
  logic signed [DIF_W-1:0] dev0, dev1;
  logic [DIF_W-1:0]        abs0, abs1;

  assign dev0 = DIF_W'(signed'(rd_q[SAMPLE_W-1:0])) - DIF_W'(mean0_q);
  assign dev1 = DIF_W'(signed'(rd_q[2*SAMPLE_W-1:SAMPLE_W])) - DIF_W'(mean1_q);
  assign abs0 = dev0[DIF_W-1] ? DIF_W'(-dev0) : DIF_W'(dev0);
  assign abs1 = dev1[DIF_W-1] ? DIF_W'(-dev1) : DIF_W'(dev1);

  // budget left for this block
  logic [CNT_W-1:0] remaining;
  logic [CW-1:0]    emit_n;

  assign remaining = (captured_q > budget_q) ? '0 : budget_q - captured_q;
  assign emit_n    = (CNT_W'(n_q) < remaining) ? n_q : remaining[CW-1:0];

  // gain multiply and saturation
  logic signed [SAMPLE_W-1:0] act_samp, act_mean;
  logic signed [DIF_W-1:0]    centered;
  logic signed [GAIN_W:0]     gain_s;
  logic signed [PRD_W-1:0]    prod_c;
  logic signed [SH_W-1:0]     shifted;
  logic signed [PCM_W-1:0]    pcm_c;

  assign act_samp = slot_q ? rd_q[2*SAMPLE_W-1:SAMPLE_W] : rd_q[SAMPLE_W-1:0];
  assign act_mean = slot_q ? mean1_q : mean0_q;
  assign centered = DIF_W'(act_samp) - DIF_W'(act_mean);
  assign gain_s   = signed'({1'b0, gain_q});
  assign prod_c   = centered * gain_s;
  assign shifted  = prod_q[PRD_W-1:GAIN_SHIFT];

  always_comb begin
    if (shifted > SH_W'(PCM_MAX)) begin
      pcm_c = PCM_MAX;
    end else if (shifted < SH_W'(PCM_MIN)) begin
      pcm_c = PCM_MIN;
    end else begin
      pcm_c = shifted[PCM_W-1:0];
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && closing) state_d = S_DIV_LD;
      end
      S_DIV_LD: state_d = S_DIV;
      S_DIV: begin
        if (dcnt_q == '0) state_d = dslot_q ? S_PK_RD : S_DIV_LD;
      end
      S_PK_RD:  state_d = S_PK_CMP;
      S_PK_CMP: begin
        state_d = (walk_q + 1'b1 == n_q) ? S_BUDGET : S_PK_RD;
      end
      S_BUDGET: state_d = (emit_n == '0) ? S_WAIT : S_EM_RD;
      S_EM_RD:  state_d = S_EM_MUL;
      S_EM_MUL: state_d = S_EM_OUT;
      S_EM_OUT: state_d = S_WAIT;
      S_WAIT: begin
        if (out_acc) state_d = out_q.last_of_block ? S_IDLE : S_EM_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fib_q       <= '0;
      sum0_q      <= '0;
      sum1_q      <= '0;
      captured_q  <= '0;
      gain_q      <= GAIN_RESET;
      slot_q      <= 1'b0;
      budget_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // configuration writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_GAIN:        gain_q <= cfg_wdata_i[GAIN_W-1:0];
          REG_ACTIVE_SLOT: slot_q <= cfg_wdata_i[0];
          REG_FRAME_BUDGET: begin
            budget_q   <= cfg_wdata_i[CNT_W-1:0];
            captured_q <= '0;
          end
          default: ;
        endcase
      end

      // frame capture
      if (in_acc) begin
        fib_q  <= fib_q + 1'b1;
        sum0_q <= sum0_q + SUM_W'(s0);
        sum1_q <= sum1_q + SUM_W'(s1);
      end

      if (state_q == S_EM_OUT) captured_q <= captured_q + 1'b1;

      // output register
      if ((state_q == S_EM_OUT) || (state_q == S_BUDGET && emit_n == '0)) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end

      // block done
      if (state_q == S_WAIT && out_acc && out_q.last_of_block) begin
        fib_q  <= '0;
        sum0_q <= '0;
        sum1_q <= '0;
      end
    end
  end

  // frame store
  always_ff @(posedge clk_i) begin
    if (in_acc) mem[fib_q[AW-1:0]] <= {s1, s0};
    rd_q <= mem[walk_q[AW-1:0]];
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) n_q <= fib_q + 1'b1;
        dslot_q <= 1'b0;
      end
      S_DIV_LD: begin
        quo_q  <= div_mag;
        rem_q  <= '0;
        dcnt_q <= DCW'(SUM_W - 1);
      end
      S_DIV: begin
        quo_q  <= quo_d;
        rem_q  <= rem_d;
        dcnt_q <= dcnt_q - 1'b1;
        if (dcnt_q == '0) begin
          if (dslot_q) mean1_q <= quo_signed[SAMPLE_W-1:0];
          else         mean0_q <= quo_signed[SAMPLE_W-1:0];
          dslot_q <= 1'b1;
          walk_q  <= '0;
          peak0_q <= '0;
          peak1_q <= '0;
        end
      end
      S_PK_RD: ;
      S_PK_CMP: begin
        if (abs0[SAMPLE_W-1:0] > peak0_q) peak0_q <= abs0[SAMPLE_W-1:0];
        if (abs1[SAMPLE_W-1:0] > peak1_q) peak1_q <= abs1[SAMPLE_W-1:0];
        walk_q <= walk_q + 1'b1;
      end
      S_BUDGET: begin
        emit_q <= emit_n;
        walk_q <= '0;
        if (emit_n == '0) begin
          out_q.pcm_sample      <= '0;
          out_q.sample_valid    <= 1'b0;
          out_q.last_of_block   <= 1'b1;
          out_q.active_mean     <= act_mean;
          out_q.slot0_peak      <= peak0_q;
          out_q.slot1_peak      <= peak1_q;
          out_q.frames_captured <= captured_q;
        end
      end
      S_EM_RD: ;
      S_EM_MUL: prod_q <= prod_c;
      S_EM_OUT: begin
        out_q.pcm_sample      <= pcm_c;
        out_q.sample_valid    <= 1'b1;
        out_q.last_of_block   <= (walk_q + 1'b1 == emit_q);
        out_q.active_mean     <= act_mean;
        out_q.slot0_peak      <= peak0_q;
        out_q.slot1_peak      <= peak1_q;
        out_q.frames_captured <= captured_q + 1'b1;
      end
      S_WAIT: begin
        if (out_acc) walk_q <= walk_q + 1'b1;
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  // no frame is taken while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_q |-> !in_ch.ready)
    else $error("frame ready while result pending");

  // block fill never reaches the block size between frames
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> fib_q < CW'(BLOCK_FRAMES))
    else $error("block fill count out of range");

  // divider never sees a zero frame count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> n_q != '0)
    else $error("divide by zero frame count");

  // a statistics-only result always closes its block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.sample_valid |-> out_q.last_of_block)
    else $error("statistics-only result not last of block");

  // the last result of a block returns the block to capture
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_q.last_of_block |=> in_ch.ready)
    else $error("block did not return to capture");
`endif

endmodule
